/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while in reset
`define LCPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// boolean condition that must never hold
`define LCPC_ASSERT_NEVER(lbl, cond, msg) \
  `LCPC_ASSERT(lbl, !(cond), msg)

`endif

/* hdl/lcpc_pkg.sv */
package lcpc_pkg;

  localparam int unsigned MAX_POINTS_DEF = 32;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned PROD_W  = 2 * DIFF_W;
  localparam int unsigned BND_W   = PROD_W + 2;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic signed [COORD_W-1:0] NEAR_Y_Q     = 16'sd102;
  localparam logic signed [COORD_W-1:0] HALF_WIDTH_Q = 16'sd179;
  localparam logic signed [COORD_W-1:0] LEFT_DEF_Q   = -16'sd179;
  localparam logic signed [COORD_W-1:0] MARGIN_Q     = 16'sd15;

  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_ADD_LEFT  = 2'd1,
    OP_ADD_RIGHT = 2'd2,
    OP_QUERY     = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    CASE_OFF    = 3'd0,
    CASE_NEAR   = 3'd1,
    CASE_WIDTH  = 3'd2,
    CASE_NOSEG  = 3'd3,
    CASE_INTERP = 3'd4
  } case_e;

  typedef enum logic [0:0] {
    REG_LANE_ENABLE = 1'b0
  } reg_e;

  typedef struct packed {
    opcode_e                    opcode;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
  } in_t;

  typedef struct packed {
    logic                       inside_res;
    case_e                      case_code;
    logic signed [COORD_W-1:0]  left_bound;
    logic signed [COORD_W-1:0]  right_bound;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
  } point_t;

endpackage

/* hdl/lcpc_ram.sv */
module lcpc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/lcpc_div.sv */
module lcpc_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [lcpc_pkg::PROD_W-1:0]  num_i,
  input  logic signed [lcpc_pkg::DIFF_W-1:0]  den_i,
  output logic                                done_o,
  output logic signed [lcpc_pkg::PROD_W-1:0]  quo_o
);
  import lcpc_pkg::*;

  localparam int unsigned MAG_W  = PROD_W;
  localparam int unsigned STEP_W = $clog2(MAG_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0]  quo_q, quo_d;
  logic [DIFF_W-1:0] rem_q, rem_d;
  logic [DIFF_W-1:0] den_q, den_d;
  logic [DIFF_W:0]   rem_sh;
  logic [DIFF_W:0]   rem_sub;
  logic              take;

  assign rem_sh  = {rem_q, quo_q[MAG_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign take    = (rem_sh >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      neg_d  = num_i[PROD_W-1] ^ den_i[DIFF_W-1];
      quo_d  = num_i[PROD_W-1] ? (~num_i + {{(MAG_W-1){1'b0}}, 1'b1}) : num_i;
      den_d  = den_i[DIFF_W-1] ? (~den_i + {{(DIFF_W-1){1'b0}}, 1'b1}) : den_i;
    end else if (busy_q) begin
      rem_d = take ? rem_sub[DIFF_W-1:0] : rem_sh[DIFF_W-1:0];
      quo_d = {quo_q[MAG_W-2:0], take};
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(MAG_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = $signed(neg_q ? (~quo_q + {{(MAG_W-1){1'b0}}, 1'b1}) : quo_q);

endmodule

/* hdl/lane_corridor_point_check_top.sv */
// Channel   Direction  Handshake                      Payload
// command   in         start high while busy low      cmd_i (in_t)
// result    out        done_o strobe, one cycle       res_o (out_t)
// config    in/out     APB, write on psel&penable&pwrite  lane_enable at byte 0
//
// Clear and append leave busy low. A disabled or empty query gives its
// result in the cycle after acceptance, a query outside the y span from
// S_SPAN after S_RD_FIRST and S_RD_LAST read the end points. Otherwise each
// list is scanned one segment per cycle, and a hit on a sloped segment costs
// one multiply plus a 34-step restoring divide on the shared divider.
// Asynchronous active-low reset clears counts, lane_enable and the sequencer.
// Results are strobed for one cycle; the receiver cannot stall them.
`include "assert_macros.svh"

module lane_corridor_point_check_top #(
  parameter int unsigned MAX_POINTS = lcpc_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  lcpc_pkg::in_t                 cmd_i,
  output logic                          done_o,
  output lcpc_pkg::out_t                res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcpc_pkg::PADDR_W-1:0]  paddr,
  input  logic [lcpc_pkg::PDATA_W-1:0]  pwdata,
  output logic [lcpc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import lcpc_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned PT_W  = $bits(point_t);

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  localparam logic signed [BND_W-1:0] SAT_HI =
    {{(BND_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [BND_W-1:0] SAT_LO =
    {{(BND_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_RD_FIRST = 11'b000_0000_0010,
    S_RD_LAST  = 11'b000_0000_0100,
    S_SPAN     = 11'b000_0000_1000,
    S_PREV     = 11'b000_0001_0000,
    S_CHK      = 11'b000_0010_0000,
    S_MUL      = 11'b000_0100_0000,
    S_DIV      = 11'b000_1000_0000,
    S_SIDE     = 11'b001_0000_0000,
    S_FIN      = 11'b010_0000_0000,
    S_OUT      = 11'b100_0000_0000
  } state_e;

  function automatic logic signed [DIFF_W-1:0] ext_d(input logic signed [COORD_W-1:0] v);
    return {v[COORD_W-1], v};
  endfunction

  function automatic logic signed [BND_W-1:0] ext_b(input logic signed [COORD_W-1:0] v);
    return {{(BND_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic signed [COORD_W-1:0] sat16(input logic signed [BND_W-1:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[COORD_W-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic out_t mk_res(input logic in_lane, input case_e code,
                                  input logic signed [COORD_W-1:0] lb,
                                  input logic signed [COORD_W-1:0] rb);
    out_t r;
    r.inside_res  = in_lane;
    r.case_code   = code;
    r.left_bound  = lb;
    r.right_bound = rb;
    return r;
  endfunction

  state_e                     state_q, state_d;
  logic                       en_q;
  logic [CNT_W-1:0]           l_cnt_q, l_cnt_d, r_cnt_q, r_cnt_d;
  logic                       side_q, side_d;
  logic [CNT_W-1:0]           idx_q, idx_d;
  logic signed [COORD_W-1:0]  qx_q, qx_d, qy_q, qy_d;
  logic signed [COORD_W-1:0]  lfy_q, lfy_d, rfy_q, rfy_d;
  point_t                     prev_q, prev_d, cur_q, cur_d;
  logic signed [PROD_W-1:0]   num_q, num_d;
  logic signed [DIFF_W-1:0]   den_q, den_d;
  logic                       div_go_q, div_go_d;
  logic                       found_l_q, found_l_d, found_r_q, found_r_d;
  logic signed [BND_W-1:0]    bnd_l_q, bnd_l_d, bnd_r_q, bnd_r_d;
  logic signed [COORD_W-1:0]  lsat_q, lsat_d, rsat_q, rsat_d;
  logic                       done_q, done_d;
  out_t                       res_q, res_d;

  logic                       l_we, r_we;
  logic [AW-1:0]              rd_addr, l_raddr, r_raddr;
  logic [PT_W-1:0]            l_rdata, r_rdata;
  point_t                     l_pt, r_pt, side_pt;
  logic [CNT_W-1:0]           l_last, r_last, side_cnt, idx_p1;

  logic signed [COORD_W-1:0]  mn_a, mn_b, mn, mx_a, mx_b, mx;
  logic signed [DIFF_W-1:0]   abs_x, abs_y, qx_e, qy_e;
  logic signed [COORD_W-1:0]  seg_lo, seg_hi;
  logic                       hit;
  logic signed [DIFF_W-1:0]   dy, ty, dx;
  logic                       div_done;
  logic signed [PROD_W-1:0]   quo;
  logic signed [BND_W-1:0]    bnd_new, l_pre, r_pre, l_marg, r_marg;
  logic signed [COORD_W-1:0]  out_lo, out_hi;
  logic                       cfg_we;

  // storage
  lcpc_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_cnt_q[AW-1:0]),
    .wdata_i ({cmd_i.pos_x, cmd_i.pos_y}),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  lcpc_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_cnt_q[AW-1:0]),
    .wdata_i ({cmd_i.pos_x, cmd_i.pos_y}),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  lcpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign l_pt     = point_t'(l_rdata);
  assign r_pt     = point_t'(r_rdata);
  assign side_pt  = (side_q == SIDE_RIGHT) ? r_pt : l_pt;
  assign side_cnt = (side_q == SIDE_RIGHT) ? r_cnt_q : l_cnt_q;
  assign l_last   = l_cnt_q - CNT_W'(1);
  assign r_last   = r_cnt_q - CNT_W'(1);
  assign idx_p1   = idx_q + CNT_W'(1);

  assign l_raddr  = (state_q == S_RD_LAST) ? l_last[AW-1:0] : rd_addr;
  assign r_raddr  = (state_q == S_RD_LAST) ? r_last[AW-1:0] : rd_addr;

  // span of the end points
  assign mn_a = (lfy_q < l_pt.y) ? lfy_q : l_pt.y;
  assign mn_b = (rfy_q < r_pt.y) ? rfy_q : r_pt.y;
  assign mn   = (mn_a < mn_b) ? mn_a : mn_b;
  assign mx_a = (lfy_q > l_pt.y) ? lfy_q : l_pt.y;
  assign mx_b = (rfy_q > r_pt.y) ? rfy_q : r_pt.y;
  assign mx   = (mx_a > mx_b) ? mx_a : mx_b;

  assign qx_e  = ext_d(qx_q);
  assign qy_e  = ext_d(qy_q);
  assign abs_x = qx_e[DIFF_W-1] ? -qx_e : qx_e;
  assign abs_y = qy_e[DIFF_W-1] ? -qy_e : qy_e;

  // segment test
  assign seg_lo = (prev_q.y < side_pt.y) ? prev_q.y : side_pt.y;
  assign seg_hi = (prev_q.y < side_pt.y) ? side_pt.y : prev_q.y;
  assign hit    = (qy_q >= seg_lo) && (qy_q <= seg_hi);

  assign dy = ext_d(cur_q.y) - ext_d(prev_q.y);
  assign ty = qy_e - ext_d(prev_q.y);
  assign dx = ext_d(cur_q.x) - ext_d(prev_q.x);

  assign bnd_new = ext_b(prev_q.x) + {{(BND_W-PROD_W){quo[PROD_W-1]}}, quo};

  assign l_pre  = found_l_q ? bnd_l_q : ext_b(LEFT_DEF_Q);
  assign r_pre  = found_r_q ? bnd_r_q : ext_b(HALF_WIDTH_Q);
  assign l_marg = l_pre + ext_b(MARGIN_Q);
  assign r_marg = r_pre - ext_b(MARGIN_Q);

  assign out_lo = (lsat_q > rsat_q) ? rsat_q : lsat_q;
  assign out_hi = (lsat_q > rsat_q) ? lsat_q : rsat_q;

  always_comb begin
    state_d   = state_q;
    l_cnt_d   = l_cnt_q;
    r_cnt_d   = r_cnt_q;
    side_d    = side_q;
    idx_d     = idx_q;
    qx_d      = qx_q;
    qy_d      = qy_q;
    lfy_d     = lfy_q;
    rfy_d     = rfy_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    num_d     = num_q;
    den_d     = den_q;
    div_go_d  = 1'b0;
    found_l_d = found_l_q;
    found_r_d = found_r_q;
    bnd_l_d   = bnd_l_q;
    bnd_r_d   = bnd_r_q;
    lsat_d    = lsat_q;
    rsat_d    = rsat_q;
    done_d    = 1'b0;
    res_d     = res_q;
    l_we      = 1'b0;
    r_we      = 1'b0;
    rd_addr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_i.opcode)
            OP_CLEAR: begin
              l_cnt_d = '0;
              r_cnt_d = '0;
            end
            OP_ADD_LEFT: begin
              if (l_cnt_q < CNT_W'(MAX_POINTS)) begin
                l_we    = 1'b1;
                l_cnt_d = l_cnt_q + CNT_W'(1);
              end
            end
            OP_ADD_RIGHT: begin
              if (r_cnt_q < CNT_W'(MAX_POINTS)) begin
                r_we    = 1'b1;
                r_cnt_d = r_cnt_q + CNT_W'(1);
              end
            end
            OP_QUERY: begin
              qx_d = cmd_i.pos_x;
              qy_d = cmd_i.pos_y;
              if (!en_q || (l_cnt_q == '0) || (r_cnt_q == '0)) begin
                done_d = 1'b1;
                res_d  = mk_res(1'b1, CASE_OFF, '0, '0);
              end else begin
                state_d = S_RD_FIRST;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_FIRST: begin
        state_d = S_RD_LAST;
      end
      S_RD_LAST: begin
        lfy_d   = l_pt.y;
        rfy_d   = r_pt.y;
        state_d = S_SPAN;
      end
      S_SPAN: begin
        if ((qy_q < mn) || (qy_q > mx)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (abs_y < ext_d(NEAR_Y_Q)) begin
            res_d = mk_res(1'b1, CASE_NEAR, '0, '0);
          end else begin
            res_d = mk_res(abs_x < ext_d(HALF_WIDTH_Q), CASE_WIDTH, '0, '0);
          end
        end else begin
          side_d    = SIDE_LEFT;
          found_l_d = 1'b0;
          found_r_d = 1'b0;
          state_d   = S_PREV;
        end
      end
      S_PREV: begin
        rd_addr = AW'(1);
        prev_d  = side_pt;
        idx_d   = CNT_W'(1);
        state_d = (side_cnt < CNT_W'(2)) ? S_SIDE : S_CHK;
      end
      S_CHK: begin
        rd_addr = idx_p1[AW-1:0];
        if (hit) begin
          cur_d   = side_pt;
          state_d = S_MUL;
        end else if (idx_p1 < side_cnt) begin
          prev_d = side_pt;
          idx_d  = idx_p1;
        end else begin
          state_d = S_SIDE;
        end
      end
      S_MUL: begin
        if (dy == '0) begin
          if (side_q == SIDE_RIGHT) begin
            found_r_d = 1'b1;
            bnd_r_d   = ext_b(prev_q.x);
          end else begin
            found_l_d = 1'b1;
            bnd_l_d   = ext_b(prev_q.x);
          end
          state_d = S_SIDE;
        end else begin
          num_d    = ty * dx;
          den_d    = dy;
          div_go_d = 1'b1;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (side_q == SIDE_RIGHT) begin
            found_r_d = 1'b1;
            bnd_r_d   = bnd_new;
          end else begin
            found_l_d = 1'b1;
            bnd_l_d   = bnd_new;
          end
          state_d = S_SIDE;
        end
      end
      S_SIDE: begin
        if (side_q == SIDE_LEFT) begin
          side_d  = SIDE_RIGHT;
          state_d = S_PREV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!found_l_q && !found_r_q) begin
          done_d  = 1'b1;
          res_d   = mk_res(1'b1, CASE_NOSEG, '0, '0);
          state_d = S_IDLE;
        end else begin
          lsat_d  = sat16(l_marg);
          rsat_d  = sat16(r_marg);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        done_d  = 1'b1;
        res_d   = mk_res((qx_q >= out_lo) && (qx_q <= out_hi), CASE_INTERP, out_lo, out_hi);
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      en_q     <= 1'b0;
      l_cnt_q  <= '0;
      r_cnt_q  <= '0;
      div_go_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      l_cnt_q  <= l_cnt_d;
      r_cnt_q  <= r_cnt_d;
      div_go_q <= div_go_d;
      done_q   <= done_d;
      if (cfg_we && (paddr[PADDR_W-1:2] == REG_LANE_ENABLE)) begin
        en_q <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_q    <= side_d;
    idx_q     <= idx_d;
    qx_q      <= qx_d;
    qy_q      <= qy_d;
    lfy_q     <= lfy_d;
    rfy_q     <= rfy_d;
    prev_q    <= prev_d;
    cur_q     <= cur_d;
    num_q     <= num_d;
    den_q     <= den_d;
    found_l_q <= found_l_d;
    found_r_q <= found_r_d;
    bnd_l_q   <= bnd_l_d;
    bnd_r_q   <= bnd_r_d;
    lsat_q    <= lsat_d;
    rsat_q    <= rsat_d;
    res_q     <= res_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_LANE_ENABLE) ?
                  {{(PDATA_W-1){1'b0}}, en_q} : '0;

  `LCPC_ASSERT(a_done_idle, done_o |-> !busy, "result strobe while sequencer still busy")
  `LCPC_ASSERT(a_done_src, done_o |-> ($past(busy) || $past(start && (cmd_i.opcode == OP_QUERY))), "result without a query")
  `LCPC_ASSERT(a_bnd_order, (done_o && (res_o.case_code == CASE_INTERP)) |-> (res_o.left_bound <= res_o.right_bound), "bounds not ordered")
  `LCPC_ASSERT_NEVER(a_div_state, div_done && (state_q != S_DIV), "divider finished outside divide state")

endmodule

/* bench/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lcpc_pkg::*;

  localparam int MAX_PTS     = MAX_POINTS_DEF;
  localparam int SETTLE_CYC  = 200;
  localparam int DRAIN_LIMIT = 5000;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                start   = 1'b0;
  logic                busy;
  in_t                 cmd_i   = '0;
  logic                done_o;
  out_t                res_o;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  lane_corridor_point_check_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .res_o   (res_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // lane store mirror: side 0 left, side 1 right
  logic signed [COORD_W-1:0] lane_x [2][MAX_PTS];
  logic signed [COORD_W-1:0] lane_y [2][MAX_PTS];
  int   lane_count [2];
  bit   lane_on;

  in_t  pending_cmds[$];
  out_t expected_verdicts[$];

  bit   taken_now;
  int   gap_pct;
  int   error_count;
  int   cmds_taken;
  int   queries_checked;
  int   items_queued;
  int   case_tally [5];

  task automatic log_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // first segment whose y range holds qy; interpolated x returned in bnd
  function automatic bit find_boundary(int side, int qy, output longint bnd);
    int x1, x2, y1, y2;
    longint dy, num;
    bnd = 0;
    for (int i = 0; i + 1 < lane_count[side]; i++) begin
      x1 = lane_x[side][i];
      x2 = lane_x[side][i+1];
      y1 = lane_y[side][i];
      y2 = lane_y[side][i+1];
      if (qy >= (y1 < y2 ? y1 : y2) && qy <= (y1 < y2 ? y2 : y1)) begin
        dy = longint'(y2) - y1;
        if (dy == 0) begin
          bnd = x1;
        end else begin
          num = (longint'(qy) - y1) * (longint'(x2) - x1);
          bnd = x1 + num / dy;
        end
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic out_t predict_verdict(int qx, int qy);
    out_t   v;
    int     ends [4];
    int     mn, mx, ax, ay;
    longint l, r, lhit, rhit, t;
    bit     fl, fr;
    v.inside_res  = 1'b1;
    v.case_code   = CASE_OFF;
    v.left_bound  = '0;
    v.right_bound = '0;
    if (!lane_on || lane_count[0] == 0 || lane_count[1] == 0) return v;
    ends[0] = lane_y[0][0];
    ends[1] = lane_y[0][lane_count[0]-1];
    ends[2] = lane_y[1][0];
    ends[3] = lane_y[1][lane_count[1]-1];
    mn = ends[0];
    mx = ends[0];
    foreach (ends[k]) begin
      if (ends[k] < mn) mn = ends[k];
      if (ends[k] > mx) mx = ends[k];
    end
    ax = qx < 0 ? -qx : qx;
    ay = qy < 0 ? -qy : qy;
    if (qy < mn || qy > mx) begin
      if (ay < NEAR_Y_Q) begin
        v.case_code = CASE_NEAR;
      end else begin
        v.case_code  = CASE_WIDTH;
        v.inside_res = ax < HALF_WIDTH_Q;
      end
      return v;
    end
    fl = find_boundary(0, qy, lhit);
    fr = find_boundary(1, qy, rhit);
    if (!fl && !fr) begin
      v.case_code = CASE_NOSEG;
      return v;
    end
    l = fl ? lhit : longint'(LEFT_DEF_Q);
    r = fr ? rhit : longint'(HALF_WIDTH_Q);
    l = clamp16(l + MARGIN_Q);
    r = clamp16(r - MARGIN_Q);
    if (l > r) begin
      t = l;
      l = r;
      r = t;
    end
    v.case_code   = CASE_INTERP;
    v.inside_res  = qx >= l && qx <= r;
    v.left_bound  = l[COORD_W-1:0];
    v.right_bound = r[COORD_W-1:0];
    return v;
  endfunction

  task automatic apply_command(in_t c);
    out_t v;
    int   s;
    case (c.opcode)
      OP_CLEAR: begin
        lane_count[0] = 0;
        lane_count[1] = 0;
      end
      OP_ADD_LEFT, OP_ADD_RIGHT: begin
        s = (c.opcode == OP_ADD_LEFT) ? 0 : 1;
        if (lane_count[s] < MAX_PTS) begin
          lane_x[s][lane_count[s]] = c.pos_x;
          lane_y[s][lane_count[s]] = c.pos_y;
          lane_count[s]++;
        end
      end
      default: begin
        v = predict_verdict(c.pos_x, c.pos_y);
        expected_verdicts = {expected_verdicts, v};
        case_tally[v.case_code]++;
      end
    endcase
  endtask

  // monitor: results first, then the transaction accepted at this edge
  always @(posedge clk_i) begin
    out_t want;
    taken_now = 1'b0;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (expected_verdicts.size() == 0) begin
          log_error("result strobed with no query outstanding");
        end else begin
          want = expected_verdicts.pop_front();
          queries_checked++;
          if (res_o.inside_res !== want.inside_res)
            log_error($sformatf("inside_res: expected %0d, got %0d",
                                want.inside_res, res_o.inside_res));
          if (res_o.case_code !== want.case_code)
            log_error($sformatf("case_code: expected %s, got %0d",
                                want.case_code.name(), res_o.case_code));
          if (res_o.left_bound !== want.left_bound)
            log_error($sformatf("left_bound: expected %0d, got %0d",
                                want.left_bound, res_o.left_bound));
          if (res_o.right_bound !== want.right_bound)
            log_error($sformatf("right_bound: expected %0d, got %0d",
                                want.right_bound, res_o.right_bound));
        end
      end
      if (start && busy === 1'b0) begin
        taken_now = 1'b1;
        cmds_taken++;
        apply_command(cmd_i);
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || taken_now) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct) begin
        cmd_i <= pending_cmds.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic int rand16();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  task automatic queue_cmd(opcode_e op, int x, int y);
    in_t c;
    c.opcode = op;
    c.pos_x  = x[COORD_W-1:0];
    c.pos_y  = y[COORD_W-1:0];
    pending_cmds = {pending_cmds, c};
    items_queued++;
  endtask

  task automatic queue_lane_scenario();
    int n, y, x, dir, step, y_lo, y_hi, n_query;
    if ($urandom_range(9) != 0) queue_cmd(OP_CLEAR, rand16(), rand16());
    y_lo = 32767;
    y_hi = -32768;
    for (int s = 0; s < 2; s++) begin
      n   = ($urandom_range(9) == 0) ? $urandom_range(36, 30) : $urandom_range(8, 1);
      y   = int'($urandom_range(4000)) - 3000;
      dir = ($urandom_range(4) == 0) ? -1 : 1;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(9) == 0) x = rand16();
        else x = (s == 0 ? -1792 : 1792) + int'($urandom_range(1200)) - 600;
        queue_cmd(s == 0 ? OP_ADD_LEFT : OP_ADD_RIGHT, x, y);
        if (y < y_lo) y_lo = y;
        if (y > y_hi) y_hi = y;
        step = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(n > 8 ? 400 : 1500));
        y += dir * step;
      end
    end
    n_query = $urandom_range(6, 2);
    for (int q = 0; q < n_query; q++) begin
      case ($urandom_range(9))
        0:       y = rand16();
        1:       y = int'($urandom_range(300)) - 150;
        default: y = y_lo - 200 + int'($urandom_range(y_hi - y_lo + 400));
      endcase
      x = ($urandom_range(7) < 2) ? rand16() : int'($urandom_range(5000)) - 2500;
      queue_cmd(OP_QUERY, x, y);
    end
    if ($urandom_range(4) == 0) queue_cmd(opcode_e'($urandom_range(3)), rand16(), rand16());
  endtask

  // waits until all commands are taken and results arrive or time out
  task automatic settle();
    int w;
    while (pending_cmds.size() != 0 || start) @(posedge clk_i);
    w = 0;
    while (expected_verdicts.size() != 0 && w < DRAIN_LIMIT) begin
      @(posedge clk_i);
      w++;
    end
    while (expected_verdicts.size() != 0) begin
      void'(expected_verdicts.pop_front());
      log_error("query result never arrived");
    end
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_lane_enable(bit on);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_LANE_ENABLE, 2'b00};
    pwdata  <= PDATA_W'(on);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
    lane_on = on;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    if (prdata !== PDATA_W'(on))
      log_error($sformatf("lane_enable readback: expected %0d, got %0h", on, prdata));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    #10ms;
    $display("FAIL lane_corridor_point_check_top");
    $finish;
  end

  initial begin
    int phase_gap [4] = '{0, 75, 16, 16};
    bit phase_en  [4] = '{1, 1, 0, 1};
    int phase_len [4] = '{110, 110, 70, 130};
    gap_pct = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // disabled: lanes ignored even when loaded
    set_lane_enable(1'b0);
    queue_cmd(OP_QUERY, 0, 0);
    queue_cmd(OP_ADD_LEFT, -1792, 0);
    queue_cmd(OP_ADD_RIGHT, 1792, 0);
    queue_cmd(OP_QUERY, -100, 50);
    queue_cmd(OP_CLEAR, 0, 0);
    settle();

    set_lane_enable(1'b1);
    queue_cmd(OP_QUERY, 0, 0);
    queue_cmd(OP_ADD_LEFT, -1792, 0);
    queue_cmd(OP_QUERY, 0, 500);
    queue_cmd(OP_ADD_RIGHT, 1792, 0);
    queue_cmd(OP_QUERY, 100, 0);          // single points, no segment
    queue_cmd(OP_ADD_RIGHT, 1600, 0);     // flat first right segment
    queue_cmd(OP_ADD_LEFT, -1536, 4096);
    queue_cmd(OP_ADD_RIGHT, 1536, 4096);
    queue_cmd(OP_QUERY, 0, 2048);
    queue_cmd(OP_QUERY, -1700, 2048);
    queue_cmd(OP_QUERY, 0, 0);
    queue_cmd(OP_QUERY, 32767, 2048);
    queue_cmd(OP_QUERY, -32768, 1024);
    queue_cmd(OP_QUERY, 50, -32768);
    queue_cmd(OP_QUERY, 32767, 32767);
    queue_cmd(OP_QUERY, -32768, -101);
    queue_cmd(OP_QUERY, 300, -102);
    // bounds saturate and cross
    queue_cmd(OP_CLEAR, 0, 0);
    queue_cmd(OP_ADD_LEFT, 32767, 0);
    queue_cmd(OP_ADD_LEFT, 32767, 1000);
    queue_cmd(OP_ADD_RIGHT, -32768, 0);
    queue_cmd(OP_ADD_RIGHT, -32768, 1000);
    queue_cmd(OP_QUERY, 0, 500);
    settle();

    for (int p = 0; p < 4; p++) begin
      set_lane_enable(phase_en[p]);
      gap_pct      = phase_gap[p];
      items_queued = 0;
      while (items_queued < phase_len[p]) queue_lane_scenario();
      settle();
    end

    $display("%0d transactions taken, %0d query results checked", cmds_taken,
             queries_checked);
    $display("results by case: off %0d, near %0d, width %0d, no segment %0d, interp %0d",
             case_tally[0], case_tally[1], case_tally[2], case_tally[3], case_tally[4]);
    if (error_count == 0) begin
      $display("PASS lane_corridor_point_check_top");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAIL lane_corridor_point_check_top");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/lcpc_pkg.sv
hdl/lcpc_ram.sv
hdl/lcpc_div.sv
hdl/lane_corridor_point_check_top.sv
bench/testbench.sv
